// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL modules of the trimmed-mean pH converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/tpc_pkg.sv =====
// Package with the constants, types and register codes of the trimmed-mean pH converter.
package tpc_pkg;

   localparam int BATCH_SIZE    = 10;
   localparam int TRIM_EACH_END = 2;
   localparam int SAMPLE_BITS   = 10;

   localparam bit HAS_MIDDLE = (2 * TRIM_EACH_END < BATCH_SIZE);
   localparam int MIDDLE     = HAS_MIDDLE ? (BATCH_SIZE - 2 * TRIM_EACH_END) : 1;
   localparam int MID_LOG    = $clog2(MIDDLE);
   localparam int CNT_W      = $clog2(BATCH_SIZE);

   localparam int OFFSET_W    = 14;
   localparam int SLOPE_W     = 12;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 2;
   localparam int PH_W        = 15;
   localparam int TSUM_W      = 13;

   localparam int SUM_W = SAMPLE_BITS + MID_LOG;
   localparam int MUL_W = SLOPE_W + SUM_W;
   localparam int P_W   = MUL_W + 4;
   localparam int X_W   = P_W - SAMPLE_BITS;

   localparam longint unsigned HALF_DIV = (longint'(MIDDLE) << SAMPLE_BITS) / 2;
   localparam int RECIP_SHIFT = X_W + MID_LOG;
   localparam longint unsigned RECIP =
      ((longint'(1) << RECIP_SHIFT) + longint'(MIDDLE) - 1) / longint'(MIDDLE);
   localparam int RECIP_W = X_W + 1;
   localparam int PROD_W  = X_W + RECIP_W;
   localparam int Q_W     = X_W;
   localparam int PHC_W   = ((Q_W > OFFSET_W) ? Q_W : OFFSET_W) + 2;

   localparam int PH_MIN = -(2 ** (PH_W - 1));
   localparam int PH_MAX = (2 ** (PH_W - 1)) - 1;

   localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(6042);
   localparam logic [SLOPE_W-1:0]  SLOPE_RESET  = SLOPE_W'(1459);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PH_OFFSET = 2'd0,
      REG_PH_SLOPE  = 2'd1
   } tpc_reg_type;

   typedef logic [SAMPLE_BITS-1:0] tpc_sample_type;
   typedef tpc_sample_type [MIDDLE-1:0] tpc_batch_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] ph_offset;
      logic [SLOPE_W-1:0]  ph_slope;
   } tpc_cfg_type;

endpackage

// ===== sv/tpc_front.sv =====
// Front end: insertion chain that keeps the current batch sorted and hands over its middle.
`include "assert_macros.svh"

module tpc_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  tpc_pkg::tpc_sample_type sample,
   output logic                    push,
   output tpc_pkg::tpc_batch_type  batch
);
   import tpc_pkg::*;

   tpc_sample_type         cell_ff [BATCH_SIZE];
   tpc_sample_type         cell_in [BATCH_SIZE];
   tpc_sample_type         cell_prev [BATCH_SIZE];
   logic [BATCH_SIZE-1:0]  gt;
   logic [BATCH_SIZE-1:0]  gt_prev;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   last;

   always_comb begin
      for (int i = 0; i < BATCH_SIZE; i++) begin
         gt[i] = (CNT_W'(i) < count_ff) && (cell_ff[i] > sample);
      end
      gt_prev      = {gt[BATCH_SIZE-2:0], 1'b0};
      cell_prev[0] = sample;
      for (int i = 1; i < BATCH_SIZE; i++) begin
         cell_prev[i] = cell_ff[i-1];
      end
      for (int i = 0; i < BATCH_SIZE; i++) begin
         if ((CNT_W'(i) < count_ff) && !gt[i]) begin
            cell_in[i] = cell_ff[i];
         end else if (gt_prev[i]) begin
            cell_in[i] = cell_prev[i];
         end else if (CNT_W'(i) <= count_ff) begin
            cell_in[i] = sample;
         end else begin
            cell_in[i] = cell_ff[i];
         end
      end
   end

   assign last = (count_ff == CNT_W'(BATCH_SIZE - 1));
   assign push = accept && last;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         count_in = last ? '0 : count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < BATCH_SIZE; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   if (HAS_MIDDLE) begin : g_mid
      always_comb begin
         for (int j = 0; j < MIDDLE; j++) begin
            batch[j] = cell_in[TRIM_EACH_END + j];
         end
      end
   end else begin : g_none
      assign batch = '0;
   end

   `ASSERT_ALWAYS(a_count_range, clock, reset, count_ff < CNT_W'(BATCH_SIZE), "batch count out of range")

endmodule

// ===== sv/tpc_queue.sv =====
// Short queue of completed batches between the sorting front end and the arithmetic back end.
`include "assert_macros.svh"

module tpc_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tpc_pkg::tpc_batch_type wdata,
   output logic                   full,
   output logic                   out_valid,
   output tpc_pkg::tpc_batch_type out_data
);
   import tpc_pkg::*;

   tpc_batch_type       mem_ff [QUEUE_DEPTH];
   tpc_batch_type       out_data_ff;
   logic                out_valid_ff;
   logic [QPTR_W-1:0]   wptr_ff;
   logic [QPTR_W-1:0]   wptr_in;
   logic [QPTR_W-1:0]   rptr_ff;
   logic [QPTR_W-1:0]   rptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;

   assign pop  = (count_ff != '0);
   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wdata;
      end
      out_data_ff <= mem_ff[rptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff      <= '0;
         rptr_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wptr_ff      <= wptr_in;
         rptr_ff      <= rptr_in;
         count_ff     <= count_in;
         out_valid_ff <= pop;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   `ASSERT_IMPLY(a_no_overflow, clock, reset, push, !full || pop, "batch pushed into a full queue")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count too large")

endmodule

// ===== sv/tpc_back.sv =====
// Back end: sums the middle samples and converts the sum to a saturated signed Q7.8 pH value.
`include "assert_macros.svh"

module tpc_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tpc_pkg::tpc_batch_type batch,
   input  tpc_pkg::tpc_cfg_type   cfg,
   output logic                   strobe,
   output logic signed [tpc_pkg::PH_W-1:0] ph_value,
   output logic [tpc_pkg::TSUM_W-1:0]      trimmed_sum,
   output logic                   saturated
);
   import tpc_pkg::*;

   logic                      v0_ff, v1_ff, v2_ff, v3_ff, strobe_ff;
   logic [SUM_W-1:0]          sum_in;
   logic [SUM_W-1:0]          sum_ff;
   logic [MUL_W-1:0]          mul_ff;
   logic [P_W-1:0]            p_in;
   logic [X_W-1:0]            x_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [TSUM_W-1:0]         ts1_ff, ts2_ff, ts3_ff, ts_out_ff;
   logic [Q_W-1:0]            q;
   logic signed [PHC_W-1:0]   ph_c;
   logic signed [PH_W-1:0]    ph_in;
   logic                      sat_in;
   logic signed [PH_W-1:0]    ph_out_ff;
   logic                      sat_out_ff;

   always_comb begin
      sum_in = '0;
      for (int j = 0; j < MIDDLE; j++) begin
         sum_in = sum_in + SUM_W'(batch[j]);
      end
   end

   assign p_in = (P_W'(mul_ff) << 2) + P_W'(mul_ff) + P_W'(HALF_DIV);
   assign q    = Q_W'(prod_ff >> RECIP_SHIFT);

   always_comb begin
      ph_c   = $signed(PHC_W'(cfg.ph_offset)) - $signed(PHC_W'(q));
      ph_in  = PH_W'(ph_c);
      sat_in = 1'b0;
      if (ph_c < PHC_W'(PH_MIN)) begin
         ph_in  = PH_W'(PH_MIN);
         sat_in = 1'b1;
      end else if (ph_c > PHC_W'(PH_MAX)) begin
         ph_in  = PH_W'(PH_MAX);
         sat_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      mul_ff     <= MUL_W'(cfg.ph_slope) * MUL_W'(sum_ff);
      ts1_ff     <= TSUM_W'(sum_ff);
      x_ff       <= X_W'(p_in >> SAMPLE_BITS);
      ts2_ff     <= ts1_ff;
      prod_ff    <= PROD_W'(x_ff) * PROD_W'(RECIP_W'(RECIP));
      ts3_ff     <= ts2_ff;
      ph_out_ff  <= ph_in;
      sat_out_ff <= sat_in;
      ts_out_ff  <= ts3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         v0_ff     <= in_valid;
         v1_ff     <= v0_ff;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         strobe_ff <= v3_ff;
      end
   end

   assign strobe      = strobe_ff;
   assign ph_value    = ph_out_ff;
   assign trimmed_sum = ts_out_ff;
   assign saturated   = sat_out_ff;

   `ASSERT_NEXT(a_pipe_flow, clock, reset, v3_ff, strobe_ff, "result lost in the back end")
   `ASSERT_IMPLY(a_sat_value, clock, reset, strobe_ff && sat_out_ff, ph_out_ff == PH_W'(PH_MIN) || ph_out_ff == PH_W'(PH_MAX), "saturated flag without a clipped value")

endmodule

// ===== sv/trimmed_mean_ph_converter_core.sv =====
// Top level of the trimmed-mean pH converter: registers, front end, batch queue and back end.
//
// One sample is taken in every clock cycle in which start is high and busy is low; the
// insertion chain places it into sorted order in that same cycle, so the block sustains
// one item per cycle while busy stays low. Every tenth item completes a batch; the batch
// then passes through the batch queue read and the five arithmetic stages (sum, slope
// multiply, scale and round, divide by six, offset subtraction with saturation), after
// which rsp_strobe is high for one cycle with the pH value, the sum of the six middle
// samples and the saturation flag. The receiver cannot stall, so results are never
// held back. A register write on the csr_ port affects every batch that has not yet reached
// the stage that uses that register; write them only while no batch is in flight. Writes
// to an index beyond ph_slope are ignored.
`include "assert_macros.svh"

module trimmed_mean_ph_converter_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [tpc_pkg::SAMPLE_BITS-1:0]   req_sample,
   output logic                              rsp_strobe,
   output logic signed [tpc_pkg::PH_W-1:0]   rsp_ph_value,
   output logic [tpc_pkg::TSUM_W-1:0]        rsp_trimmed_sum,
   output logic                              rsp_saturated,
   input  logic                              csr_write_enable,
   input  logic [tpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tpc_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import tpc_pkg::*;

   tpc_cfg_type    cfg_ff;
   tpc_cfg_type    cfg_in;
   logic           accept;
   logic           push;
   logic           full;
   logic           q_valid;
   tpc_batch_type  front_batch;
   tpc_batch_type  q_batch;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_PH_OFFSET: cfg_in.ph_offset = OFFSET_W'(csr_write_data);
            REG_PH_SLOPE:  cfg_in.ph_slope  = SLOPE_W'(csr_write_data);
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ph_offset <= OFFSET_RESET;
         cfg_ff.ph_slope  <= SLOPE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy   = full;
   assign accept = start && !busy;

   tpc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .push   (push),
      .batch  (front_batch)
   );

   tpc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wdata     (front_batch),
      .full      (full),
      .out_valid (q_valid),
      .out_data  (q_batch)
   );

   tpc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .batch       (q_batch),
      .cfg         (cfg_ff),
      .strobe      (rsp_strobe),
      .ph_value    (rsp_ph_value),
      .trimmed_sum (rsp_trimmed_sum),
      .saturated   (rsp_saturated)
   );

endmodule
